/* hw/rtl/spjf_pkg.sv */
// types, constants and the short-range distance helper for the stroke point jitter filter
// no dependencies
package spjf_pkg;

    localparam int STROKE_MAX  = 128;
    localparam int COORD_BITS  = 12;
    localparam int LEN_W       = $clog2(STROKE_MAX + 1);
    localparam int DATA_W      = ((2 * COORD_BITS + 7) / 8) * 8;
    localparam int LIMIT_W     = 8;
    localparam int NEAR_BITS   = LIMIT_W / 2;
    localparam int SQ_W        = 2 * NEAR_BITS + 1;
    localparam int FAR_TAIL_SQ = 100;
    localparam int FIFO_DEPTH  = 8;
    localparam int PTR_W       = $clog2(FIFO_DEPTH);
    localparam int CNT_W       = $clog2(FIFO_DEPTH + 1);
    localparam int MAX_RES     = 3;

    typedef enum logic [1:0] {
        FUNC_PRESS   = 2'd0,
        FUNC_RELEASE = 2'd1,
        FUNC_MOVE    = 2'd2
    } t_func;

    typedef enum logic [1:0] {
        ACT_APPEND = 2'd0,
        ACT_REMOVE = 2'd1,
        ACT_START  = 2'd2
    } t_action;

    typedef enum logic {
        CFG_MOVE_LIMIT   = 1'b0,
        CFG_JITTER_LIMIT = 1'b1
    } t_cfg_index;

    typedef struct packed {
        t_action               action;
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic                  last;
    } t_result;

    typedef struct packed {
        logic            far;
        logic [SQ_W-1:0] sq;
    } t_dist;

    // squared distance, exact only below the range any 8-bit limit can reach
    function automatic t_dist near_dist(
        input logic [COORD_BITS-1:0] ax,
        input logic [COORD_BITS-1:0] ay,
        input logic [COORD_BITS-1:0] bx,
        input logic [COORD_BITS-1:0] by
    );
        logic [COORD_BITS-1:0] dx;
        logic [COORD_BITS-1:0] dy;
        logic [SQ_W-1:0]       nx;
        logic [SQ_W-1:0]       ny;
        t_dist                 d;
        dx = (ax >= bx) ? (ax - bx) : (bx - ax);
        dy = (ay >= by) ? (ay - by) : (by - ay);
        nx = SQ_W'(dx[NEAR_BITS-1:0]);
        ny = SQ_W'(dy[NEAR_BITS-1:0]);
        d.far = (|dx[COORD_BITS-1:NEAR_BITS]) | (|dy[COORD_BITS-1:NEAR_BITS]);
        d.sq  = (nx * nx) + (ny * ny);
        return d;
    endfunction

endpackage

/* hw/rtl/stroke_point_jitter_filter_unit.sv */
// stroke point jitter filter: pen events in, stroke list edits out
// depends on spjf_pkg
// an accepted beat goes through the input register, then its results into the result queue
// throughput: one input beat per cycle while results are taken; one result beat per cycle out
// while taken; several results per input hold the input side until two or fewer are queued
// reset: synchronous active low, clears pen state, limits to defaults and empties the queue
module stroke_point_jitter_filter_unit (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_wr_en,
    input  logic                                  i_cfg_index,
    input  logic [spjf_pkg::LIMIT_W-1:0]          i_cfg_data,
    input  logic                                  i_s_tvalid,
    output logic                                  o_s_tready,
    input  logic [spjf_pkg::DATA_W-1:0]           i_s_tdata,   // pos_x, pos_y, zero pad
    input  logic [1:0]                            i_s_tuser,   // func
    output logic                                  o_m_tvalid,
    input  logic                                  i_m_tready,
    output logic [spjf_pkg::DATA_W-1:0]           o_m_tdata,   // out_x, out_y, zero pad
    output logic [1:0]                            o_m_tuser,   // action
    output logic                                  o_m_tlast    // final_res
);
    import spjf_pkg::*;

    logic [LIMIT_W-1:0]    r_move_limit;
    logic [LIMIT_W-1:0]    r_jitter_limit;

    logic                  r_in_valid;
    logic [1:0]            r_in_func;
    logic [COORD_BITS-1:0] r_in_x;
    logic [COORD_BITS-1:0] r_in_y;

    logic                  r_drawing,  n_drawing;
    logic [COORD_BITS-1:0] r_tail_x,   n_tail_x;
    logic [COORD_BITS-1:0] r_tail_y,   n_tail_y;
    logic [LEN_W-1:0]      r_len,      n_len;
    logic                  r_anc_vld,  n_anc_vld;
    logic [COORD_BITS-1:0] r_anc_x,    n_anc_x;
    logic [COORD_BITS-1:0] r_anc_y,    n_anc_y;
    logic                  r_pending,  n_pending;

    t_result               r_fifo [FIFO_DEPTH];
    logic [PTR_W-1:0]      r_wptr;
    logic [PTR_W-1:0]      r_rptr;
    logic [CNT_W-1:0]      r_count;

    t_result               res [MAX_RES];
    logic [1:0]            push_num;
    logic                  pop;
    t_dist                 d_tail;
    t_dist                 d_anc;
    logic                  tail_close;
    logic                  anc_close;
    logic                  suspect;
    logic                  do_remove;
    logic [LEN_W-1:0]      len_app;
    logic                  restart;
    t_result               head;
    logic                  s_acc;

    assign s_acc      = i_s_tvalid && o_s_tready;
    assign o_s_tready = (r_count <= CNT_W'(FIFO_DEPTH - 2 * MAX_RES));
    assign pop        = o_m_tvalid && i_m_tready;

    // config and input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_move_limit   <= LIMIT_W'(5);
            r_jitter_limit <= LIMIT_W'(15);
            r_in_valid     <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                unique case (t_cfg_index'(i_cfg_index))
                    CFG_MOVE_LIMIT:   r_move_limit   <= i_cfg_data;
                    CFG_JITTER_LIMIT: r_jitter_limit <= i_cfg_data;
                    default: ;
                endcase
            end
            r_in_valid <= s_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_in_func <= i_s_tuser;
            r_in_x    <= i_s_tdata[COORD_BITS-1:0];
            r_in_y    <= i_s_tdata[2*COORD_BITS-1:COORD_BITS];
        end
    end

    // event evaluation
    always_comb begin
        d_tail     = near_dist(r_tail_x, r_tail_y, r_in_x, r_in_y);
        d_anc      = near_dist(r_anc_x, r_anc_y, r_in_x, r_in_y);
        tail_close = (r_len == '0) ? (LIMIT_W'(FAR_TAIL_SQ) < r_move_limit)
                                   : (!d_tail.far && (d_tail.sq < SQ_W'(r_move_limit)));
        anc_close  = r_anc_vld && !d_anc.far && (d_anc.sq <= SQ_W'(r_jitter_limit));
        suspect    = tail_close && anc_close;
        do_remove  = r_pending && (r_len != '0);
        len_app    = r_len - LEN_W'(do_remove) + LEN_W'(1);
        restart    = (len_app >= LEN_W'(STROKE_MAX));
    end

    always_comb begin
        n_drawing = r_drawing;
        n_tail_x  = r_tail_x;
        n_tail_y  = r_tail_y;
        n_len     = r_len;
        n_anc_vld = r_anc_vld;
        n_anc_x   = r_anc_x;
        n_anc_y   = r_anc_y;
        n_pending = r_pending;
        push_num  = 2'd0;
        for (int i = 0; i < MAX_RES; i++) begin
            res[i] = '{action: ACT_APPEND, x: r_in_x, y: r_in_y, last: 1'b0};
        end
        if (r_in_valid) begin
            unique case (r_in_func)
                FUNC_PRESS: begin
                    n_drawing = 1'b1;
                    n_tail_x  = r_in_x;
                    n_tail_y  = r_in_y;
                    n_len     = LEN_W'(2);
                    res[0]    = '{action: ACT_START, x: r_in_x, y: r_in_y, last: 1'b1};
                    push_num  = 2'd1;
                end
                FUNC_RELEASE: begin
                    n_drawing = 1'b0;
                    n_anc_vld = 1'b0;
                end
                FUNC_MOVE: begin
                    if (r_drawing) begin
                        n_tail_x  = r_in_x;
                        n_tail_y  = r_in_y;
                        n_pending = suspect && !restart;
                        n_len     = restart ? LEN_W'(2) : len_app;
                        if (!suspect) begin
                            n_anc_vld = 1'b1;
                            n_anc_x   = r_in_x;
                            n_anc_y   = r_in_y;
                        end
                        if (do_remove) begin
                            res[0]   = '{action: ACT_REMOVE, x: '0, y: '0, last: 1'b0};
                            push_num = 2'd1;
                        end
                        res[push_num] = '{action: ACT_APPEND, x: r_in_x, y: r_in_y,
                                          last: !restart};
                        push_num = push_num + 2'd1;
                        if (restart) begin
                            res[push_num] = '{action: ACT_START, x: r_in_x, y: r_in_y,
                                              last: 1'b1};
                            push_num = push_num + 2'd1;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_drawing <= 1'b0;
            r_tail_x  <= '0;
            r_tail_y  <= '0;
            r_len     <= '0;
            r_anc_vld <= 1'b0;
            r_anc_x   <= '0;
            r_anc_y   <= '0;
            r_pending <= 1'b0;
        end else begin
            r_drawing <= n_drawing;
            r_tail_x  <= n_tail_x;
            r_tail_y  <= n_tail_y;
            r_len     <= n_len;
            r_anc_vld <= n_anc_vld;
            r_anc_x   <= n_anc_x;
            r_anc_y   <= n_anc_y;
            r_pending <= n_pending;
        end
    end

    // result queue
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < MAX_RES; i++) begin
            if (2'(i) < push_num) begin
                r_fifo[r_wptr + PTR_W'(i)] <= res[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= r_wptr + PTR_W'(push_num);
            r_rptr  <= r_rptr + PTR_W'(pop);
            r_count <= r_count + CNT_W'(push_num) - CNT_W'(pop);
        end
    end

    assign head       = r_fifo[r_rptr];
    assign o_m_tvalid = (r_count != '0);
    assign o_m_tdata  = {{(DATA_W - 2 * COORD_BITS){1'b0}}, head.y, head.x};
    assign o_m_tuser  = head.action;
    assign o_m_tlast  = head.last;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(FIFO_DEPTH))
        else $error("result queue overflow");

    a_count_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && (r_count == '0) && !i_m_tready |=> r_count == CNT_W'($past(push_num)))
        else $error("result count does not follow pushes");

    a_move_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && (r_in_func == FUNC_MOVE) && r_drawing |-> push_num != 2'd0)
        else $error("move while drawing gave no result");

    a_len_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_drawing |-> (r_len >= LEN_W'(2)) && (r_len < LEN_W'(STROKE_MAX)))
        else $error("stroke length out of range while drawing");

    a_anchor_drawing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_anc_vld |-> r_drawing)
        else $error("anchor valid while pen is up");

endmodule

/* sim/tb_stroke_point_jitter_filter_unit.sv */
// self-checking testbench for stroke_point_jitter_filter_unit: pen events in, stroke edits checked
// a scoreboard class predicts every result beat from the pen events taken; depends on spjf_pkg
`timescale 1ns / 1ps

module tb_stroke_point_jitter_filter_unit;
    import spjf_pkg::*;

    localparam int          CLK_HALF    = 10;
    localparam int          RESET_CYC   = 7;
    localparam int          IDLE_PCT    = 17;
    localparam int          SETTLE_CYC  = 6;
    localparam int          CYCLE_LIMIT = 300000;
    localparam int          COORD_MAX   = (1 << COORD_BITS) - 1;
    localparam int          TAIL_FAR    = FAR_TAIL_SQ;
    localparam int          ANCHOR_FAR  = 500;
    localparam logic [1:0]  FUNC_UNUSED = 2'd3;

    class stroke_scoreboard;
        logic [LIMIT_W-1:0]    move_lim;
        logic [LIMIT_W-1:0]    jit_lim;
        bit                    drawing;
        logic [COORD_BITS-1:0] tail_x;
        logic [COORD_BITS-1:0] tail_y;
        int unsigned           stroke_len;
        bit                    anchor_ok;
        logic [COORD_BITS-1:0] anchor_x;
        logic [COORD_BITS-1:0] anchor_y;
        bit                    remove_due;
        t_result               batch[$];
        t_result               expected[$];
        int                    errors;
        int                    beats;
        int                    restarts;
        int                    removals;

        function new();
            move_lim   = 8'd5;
            jit_lim    = 8'd15;
            drawing    = 0;
            tail_x     = '0;
            tail_y     = '0;
            stroke_len = 0;
            anchor_ok  = 0;
            anchor_x   = '0;
            anchor_y   = '0;
            remove_due = 0;
        endfunction

        function void set_limit(t_cfg_index idx, logic [LIMIT_W-1:0] v);
            if (idx == CFG_MOVE_LIMIT)
                move_lim = v;
            else
                jit_lim = v;
        endfunction

        function int unsigned dist_sq(logic [COORD_BITS-1:0] ax, logic [COORD_BITS-1:0] ay,
                                      logic [COORD_BITS-1:0] bx, logic [COORD_BITS-1:0] by);
            int unsigned dx;
            int unsigned dy;
            dx = (ax >= bx) ? ax - bx : bx - ax;
            dy = (ay >= by) ? ay - by : by - ay;
            return dx * dx + dy * dy;
        endfunction

        function void queue_edit(t_action act, logic [COORD_BITS-1:0] x,
                                 logic [COORD_BITS-1:0] y);
            t_result r;
            r.action = act;
            r.x      = x;
            r.y      = y;
            r.last   = 1'b0;
            batch.push_back(r);
        endfunction

        function void start_stroke(logic [COORD_BITS-1:0] x, logic [COORD_BITS-1:0] y);
            tail_x     = x;
            tail_y     = y;
            stroke_len = 2;
            drawing    = 1;
        endfunction

        function void note_event(logic [1:0] kind, logic [COORD_BITS-1:0] x,
                                 logic [COORD_BITS-1:0] y);
            int unsigned d_tail;
            int unsigned d_anchor;
            batch.delete();
            if (kind == FUNC_PRESS) begin
                start_stroke(x, y);
                queue_edit(ACT_START, x, y);
            end else if (kind == FUNC_RELEASE) begin
                drawing   = 0;
                anchor_ok = 0;
            end else if (kind == FUNC_MOVE && drawing) begin
                d_tail   = (stroke_len != 0) ? dist_sq(tail_x, tail_y, x, y) : TAIL_FAR;
                d_anchor = anchor_ok ? dist_sq(anchor_x, anchor_y, x, y) : ANCHOR_FAR;
                // marked point goes first, tail distance was taken against it
                if (remove_due) begin
                    if (stroke_len > 0) begin
                        stroke_len--;
                        queue_edit(ACT_REMOVE, '0, '0);
                        removals++;
                    end
                    remove_due = 0;
                end
                if (d_tail < move_lim && d_anchor <= jit_lim) begin
                    remove_due = 1;
                end else begin
                    anchor_ok = 1;
                    anchor_x  = x;
                    anchor_y  = y;
                end
                queue_edit(ACT_APPEND, x, y);
                stroke_len++;
                tail_x = x;
                tail_y = y;
                if (stroke_len >= STROKE_MAX) begin
                    start_stroke(x, y);
                    remove_due = 0;
                    queue_edit(ACT_START, x, y);
                    restarts++;
                end
            end
            if (batch.size() > 0)
                batch[$].last = 1'b1;
            foreach (batch[i])
                expected.push_back(batch[i]);
        endfunction

        task report_mismatch(string msg);
            errors++;
            $display("mismatch: %s", msg);
        endtask

        task check_result(logic [1:0] act, logic [COORD_BITS-1:0] x, logic [COORD_BITS-1:0] y,
                          logic last);
            t_result want;
            beats++;
            if (expected.size() == 0) begin
                report_mismatch($sformatf("result %0d arrived with nothing expected", beats));
                return;
            end
            want = expected.pop_front();
            if (act !== want.action)
                report_mismatch($sformatf("result %0d action got %0d expected %0d",
                                          beats, act, want.action));
            if (x !== want.x)
                report_mismatch($sformatf("result %0d out_x got %0d expected %0d",
                                          beats, x, want.x));
            if (y !== want.y)
                report_mismatch($sformatf("result %0d out_y got %0d expected %0d",
                                          beats, y, want.y));
            if (last !== want.last)
                report_mismatch($sformatf("result %0d final_res got %0d expected %0d",
                                          beats, last, want.last));
        endtask
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_wr_en;
    logic                  i_cfg_index;
    logic [LIMIT_W-1:0]    i_cfg_data;
    logic                  i_s_tvalid;
    logic                  o_s_tready;
    logic [DATA_W-1:0]     i_s_tdata;
    logic [1:0]            i_s_tuser;
    logic                  o_m_tvalid;
    logic                  i_m_tready;
    logic [DATA_W-1:0]     o_m_tdata;
    logic [1:0]            o_m_tuser;
    logic                  o_m_tlast;

    stroke_scoreboard      sb;
    bit                    no_idle = 0;
    int                    cycle_count = 0;
    int                    events_sent = 0;
    int                    settings = 0;
    int                    px;
    int                    py;

    stroke_point_jitter_filter_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .o_m_tlast   (o_m_tlast)
    );

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    always @(posedge i_clk)
        cycle_count <= cycle_count + 1;

    initial begin
        while (cycle_count < CYCLE_LIMIT)
            @(posedge i_clk);
        $display("timeout after %0d cycles, %0d results still expected",
                 cycle_count, sb.expected.size());
        $display("Mismatches found");
        $finish;
    end

    // result side: random back-pressure unless no_idle is set, check every beat taken
    initial begin
        i_m_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_m_tvalid && i_m_tready)
                sb.check_result(o_m_tuser, o_m_tdata[COORD_BITS-1:0],
                                o_m_tdata[2*COORD_BITS-1:COORD_BITS], o_m_tlast);
            i_m_tready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    function automatic int clamp_coord(int v);
        if (v < 0)
            return 0;
        if (v > COORD_MAX)
            return COORD_MAX;
        return v;
    endfunction

    task automatic send_event(logic [1:0] kind, int x, int y);
        while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= kind;
        i_s_tdata  <= DATA_W'({y[COORD_BITS-1:0], x[COORD_BITS-1:0]});
        @(posedge i_clk);
        while (!o_s_tready)
            @(posedge i_clk);
        sb.note_event(kind, x[COORD_BITS-1:0], y[COORD_BITS-1:0]);
        events_sent++;
    endtask

    // hold off the sender until every expected beat is back and the pipe is quiet
    task automatic drain();
        i_s_tvalid <= 1'b0;
        while (sb.expected.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    task automatic set_limits(logic [LIMIT_W-1:0] move_v, logic [LIMIT_W-1:0] jit_v);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= CFG_MOVE_LIMIT;
        i_cfg_data  <= move_v;
        @(posedge i_clk);
        i_cfg_index <= CFG_JITTER_LIMIT;
        i_cfg_data  <= jit_v;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        sb.set_limit(CFG_MOVE_LIMIT, move_v);
        sb.set_limit(CFG_JITTER_LIMIT, jit_v);
        settings++;
    endtask

    // press, a walk of small steps with some jumps, then usually a release
    task automatic pen_stroke(int moves, int spread);
        int r;
        int dx;
        int dy;
        px = $urandom_range(COORD_MAX);
        py = $urandom_range(COORD_MAX);
        send_event(FUNC_PRESS, px, py);
        repeat (moves) begin
            r = $urandom_range(99);
            if (r < 5) begin
                px = $urandom_range(COORD_MAX);
                py = $urandom_range(COORD_MAX);
            end else if (r < 15) begin
                dx = $urandom_range(64);
                dy = $urandom_range(64);
                px = clamp_coord(px + dx - 32);
                py = clamp_coord(py + dy - 32);
            end else begin
                dx = $urandom_range(2 * spread);
                dy = $urandom_range(2 * spread);
                px = clamp_coord(px + dx - spread);
                py = clamp_coord(py + dy - spread);
            end
            send_event(FUNC_MOVE, px, py);
        end
        if ($urandom_range(99) < 75)
            send_event(FUNC_RELEASE, $urandom_range(COORD_MAX), $urandom_range(COORD_MAX));
    endtask

    task automatic random_phase(int n_items, int long_moves);
        int sent;
        int len;
        sent = 0;
        if (long_moves > 0) begin
            pen_stroke(long_moves, 20);
            sent += long_moves + 2;
        end
        while (sent < n_items) begin
            if ($urandom_range(99) < 10) begin
                send_event(2'($urandom_range(3)), $urandom_range(COORD_MAX),
                           $urandom_range(COORD_MAX));
                sent++;
            end else begin
                len = $urandom_range(24, 1);
                pen_stroke(len, $urandom_range(8, 1));
                sent += len + 2;
            end
        end
    endtask

    initial begin
        sb = new();
        i_rst_n     <= 1'b0;
        i_cfg_wr_en <= 1'b0;
        i_cfg_index <= CFG_MOVE_LIMIT;
        i_cfg_data  <= '0;
        i_s_tvalid  <= 1'b0;
        i_s_tdata   <= '0;
        i_s_tuser   <= FUNC_PRESS;
        repeat (RESET_CYC) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part on the reset limits
        send_event(FUNC_MOVE, 100, 100);
        send_event(FUNC_UNUSED, 55, 66);
        send_event(FUNC_RELEASE, 0, 0);
        send_event(FUNC_PRESS, 0, 0);
        send_event(FUNC_MOVE, 1, 1);
        send_event(FUNC_MOVE, 2, 1);
        send_event(FUNC_MOVE, 3, 2);
        send_event(FUNC_RELEASE, COORD_MAX, 0);
        send_event(FUNC_PRESS, COORD_MAX, COORD_MAX);
        send_event(FUNC_MOVE, COORD_MAX - 1, COORD_MAX);
        send_event(FUNC_MOVE, COORD_MAX, COORD_MAX - 1);
        send_event(FUNC_PRESS, 2048, 2048);
        send_event(FUNC_MOVE, 2049, 2048);
        send_event(FUNC_MOVE, 2100, 2000);
        send_event(FUNC_MOVE, 2101, 2001);
        send_event(FUNC_MOVE, 2100, 2000);
        send_event(FUNC_MOVE, COORD_MAX, 0);
        send_event(FUNC_MOVE, 0, COORD_MAX);
        send_event(FUNC_RELEASE, 1234, 2345);
        send_event(FUNC_MOVE, 0, 0);
        send_event(FUNC_UNUSED, COORD_MAX, COORD_MAX);
        drain();

        for (int p = 0; p < 4; p++) begin
            case (p)
                0: set_limits(8'd0, 8'd0);
                1: set_limits(8'd255, 8'd255);
                2: set_limits(8'($urandom_range(255)), 8'($urandom_range(255)));
                default: set_limits(8'd40, 8'd255);
            endcase
            no_idle = (p == 2);
            random_phase(25, (p == 0) ? 135 : 0);
            drain();
        end
        no_idle = 0;

        $display("%0d pen events over %0d limit settings gave %0d result beats",
                 events_sent, settings, sb.beats);
        $display("%0d jitter points removed, %0d strokes restarted when full",
                 sb.removals, sb.restarts);
        if (sb.errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
